// ----- hdl/window_matte_blend_assert.svh -----
// Assertion macros for the window matte blend block.
`ifndef WINDOW_MATTE_BLEND_ASSERT_SVH
`define WINDOW_MATTE_BLEND_ASSERT_SVH
// Implication checked every clock outside reset.
`define WMB_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define WMB_ASSERT_NXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

// ----- hdl/wmb_pkg.sv -----
// Package for the window matte blend block: payload types and constants.
package wmb_pkg;

  typedef struct packed {
    logic [15:0] pos_h;
    logic [15:0] pos_v;
    logic [15:0] src_red;
    logic [15:0] src_green;
    logic [15:0] src_blue;
    logic [15:0] src_alpha;
    logic [15:0] graded_red;
    logic [15:0] graded_green;
    logic [15:0] graded_blue;
  } wmb_in_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic [16:0] matte_value;
  } wmb_out_t;

  // Register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_CENTER_H = 3'd1;
  localparam logic [2:0] REG_CENTER_V = 3'd2;
  localparam logic [2:0] REG_ANGLE    = 3'd3;
  localparam logic [2:0] REG_SIZE_H   = 3'd4;
  localparam logic [2:0] REG_SIZE_V   = 3'd5;
  localparam logic [2:0] REG_FEATHER  = 3'd6;
  localparam logic [2:0] REG_STRENGTH = 3'd7;

  // Shape codes
  localparam logic [1:0] SHAPE_ELLIPSE = 2'd0;
  localparam logic [1:0] SHAPE_RECT    = 2'd1;
  localparam logic [1:0] SHAPE_LINEAR  = 2'd2;

  localparam int CORDIC_STEPS = 18;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032875;

  function automatic logic signed [23:0] atan_step(input logic [4:0] i);
    case (i)
      5'd0:  atan_step = 24'sd2097152;
      5'd1:  atan_step = 24'sd1238021;
      5'd2:  atan_step = 24'sd654136;
      5'd3:  atan_step = 24'sd332050;
      5'd4:  atan_step = 24'sd166669;
      5'd5:  atan_step = 24'sd83416;
      5'd6:  atan_step = 24'sd41718;
      5'd7:  atan_step = 24'sd20860;
      5'd8:  atan_step = 24'sd10430;
      5'd9:  atan_step = 24'sd5215;
      5'd10: atan_step = 24'sd2608;
      5'd11: atan_step = 24'sd1304;
      5'd12: atan_step = 24'sd652;
      5'd13: atan_step = 24'sd326;
      5'd14: atan_step = 24'sd163;
      5'd15: atan_step = 24'sd81;
      5'd16: atan_step = 24'sd41;
      5'd17: atan_step = 24'sd20;
      default: atan_step = 24'sd0;
    endcase
  endfunction

endpackage

// ----- hdl/wmb_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, Q_BITS-bit quotient with overflow flag.
module wmb_div
  import wmb_pkg::*;
#(
  parameter int NUM_BITS = 40,
  parameter int DEN_BITS = 20,
  parameter int Q_BITS   = 18,
  parameter int TAG_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  input  logic [TAG_BITS-1:0] tag_in,
  output logic                out_valid,
  output logic [Q_BITS-1:0]   quo,
  output logic                ovf,
  output logic [TAG_BITS-1:0] tag_out
);
  // Quotient bits at and above Q_BITS only flag overflow.
  localparam int RW = DEN_BITS + 1;

  logic [NUM_BITS-1:0] n_q [Q_BITS+1];
  logic [DEN_BITS-1:0] d_q [Q_BITS+1];
  logic [RW-1:0]       r_q [Q_BITS+1];
  logic [Q_BITS-1:0]   q_q [Q_BITS+1];
  logic                o_q [Q_BITS+1];
  logic [TAG_BITS-1:0] t_q [Q_BITS+1];
  logic                v_q [Q_BITS+1];

  // Stage 0: flag overflow when the high part is not below den or den is zero.
  logic [RW-1:0] r0;
  logic          o0;
  always_comb begin
    logic [NUM_BITS-Q_BITS-1:0] hi;
    hi = num[NUM_BITS-1:Q_BITS];
    o0 = ({{(NUM_BITS+DEN_BITS){1'b0}}, hi} >=
          {{(NUM_BITS){1'b0}}, {(NUM_BITS-Q_BITS){1'b0}}, den}) || (den == '0);
    r0 = RW'(hi);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_q[0] <= num;
      d_q[0] <= den;
      r_q[0] <= r0;
      q_q[0] <= '0;
      o_q[0] <= o0;
      t_q[0] <= tag_in;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v_q[0] <= 1'b0;
    else if (en) v_q[0] <= in_valid;
  end

  for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
    logic [RW:0]   trial;
    logic          take;
    logic [RW-1:0] rn;
    always_comb begin
      trial = {r_q[k], n_q[k][Q_BITS-1-k]};
      take  = trial >= {2'b00, d_q[k]};
      rn    = take ? RW'(trial - {2'b00, d_q[k]}) : RW'(trial);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_q[k+1] <= n_q[k];
        d_q[k+1] <= d_q[k];
        r_q[k+1] <= rn;
        q_q[k+1] <= q_q[k] | (Q_BITS'(take) << (Q_BITS-1-k));
        o_q[k+1] <= o_q[k];
        t_q[k+1] <= t_q[k];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) v_q[k+1] <= 1'b0;
      else if (en) v_q[k+1] <= v_q[k];
    end
  end

  assign out_valid = v_q[Q_BITS];
  assign quo       = q_q[Q_BITS];
  assign ovf       = o_q[Q_BITS];
  assign tag_out   = t_q[Q_BITS];
endmodule

// ----- hdl/window_matte_blend.sv -----
// Top level of the window matte blend block.
// Pixel pipeline: one word in and one word out per clock when not stalled. A
// word passes through the bit-per-stage dividers (axis ratio pair, feather ramp,
// 19 stages each) and the 20-stage bit-per-stage square root on its way to the
// output. The whole pipeline advances together; out stall freezes it and the
// output register, and a new word is taken whenever the last stage can move and
// no angle update is pending or running.
// Sine and cosine come from a CORDIC run once per angle write (and after reset)
// by a sequencer; an angle write holds off pixel words while it runs.
module window_matte_blend
  import wmb_pkg::*;
#(
  parameter int FRAC_BITS    = 16,
  parameter int CHANNEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  wmb_in_t     in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output wmb_out_t    out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
`include "window_matte_blend_assert.svh"

  localparam int ONE_I = 1 << FRAC_BITS;
  localparam int EPS_T = (ONE_I + 5000) / 10000;
  localparam int EPS_I = (EPS_T < 1) ? 1 : EPS_T;
  localparam int SH    = FRAC_BITS - 16;
  localparam int QB    = FRAC_BITS + 2;        // capped quotient bits (2*ONE)
  localparam int NB    = 40 + FRAC_BITS;       // dividend bits
  localparam int DB    = 20;                   // divisor bits

  // ---------------- configuration registers
  logic [2:0]         mode;
  logic signed [17:0] ctr_h, ctr_v;
  logic [15:0]        angle;
  logic [17:0]        size_h, size_v, feather;
  logic [16:0]        strength;
  logic               angle_dirty;

  // CORDIC sequencer, one step per cycle, busy blocks pixels
  logic signed [33:0] cx, cy;
  logic signed [25:0] cz;
  logic [4:0]         cstep;
  logic               cbusy, cflip;
  logic signed [33:0] cos_q, sin_q;

  assign cfg_ready = ~cbusy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0; ctr_h <= 18'sd32768; ctr_v <= 18'sd32768; angle <= '0;
      size_h <= 18'd65536; size_v <= 18'd65536; feather <= 18'd6554;
      strength <= 17'd65536; angle_dirty <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:     mode <= cfg_data[2:0];
          REG_CENTER_H: ctr_h <= cfg_data[17:0];
          REG_CENTER_V: ctr_v <= cfg_data[17:0];
          REG_ANGLE: begin
            angle <= cfg_data[15:0];
            angle_dirty <= 1'b1;
          end
          REG_SIZE_H:   size_h <= cfg_data[17:0];
          REG_SIZE_V:   size_v <= cfg_data[17:0];
          REG_FEATHER:  feather <= cfg_data[17:0];
          REG_STRENGTH: strength <= cfg_data[16:0];
          default: ;
        endcase
      end else if (angle_dirty && !cbusy) begin
        angle_dirty <= 1'b0;
      end
    end
  end

  // CORDIC iteration
  logic signed [17:0] th;
  always_comb begin
    th = -18'(signed'(angle));
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      cbusy <= 1'b0; cstep <= '0;
    end else if (!cbusy && angle_dirty && !(cfg_valid && cfg_ready)) begin
      cbusy <= 1'b1;
      cstep <= '0;
      cx <= 34'(CORDIC_GAIN);
      cy <= '0;
      if (th > 18'sd16384) begin
        cz <= 26'((th - 18'sd32768) * 256); cflip <= 1'b1;
      end else if (th < -18'sd16384) begin
        cz <= 26'((th + 18'sd32768) * 256); cflip <= 1'b1;
      end else begin
        cz <= 26'(th * 256); cflip <= 1'b0;
      end
    end else if (cbusy) begin
      if (cz >= 0) begin
        cx <= cx - (cy >>> cstep);
        cy <= cy + (cx >>> cstep);
        cz <= cz - 26'(atan_step(cstep));
      end else begin
        cx <= cx + (cy >>> cstep);
        cy <= cy - (cx >>> cstep);
        cz <= cz + 26'(atan_step(cstep));
      end
      if (cstep == 5'(CORDIC_STEPS - 1)) begin
        cbusy <= 1'b0;
      end
      cstep <= cstep + 5'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (cbusy && cstep == 5'(CORDIC_STEPS - 1)) begin
      if (cz >= 0) begin
        cos_q <= cflip ? -(cx - (cy >>> cstep)) : (cx - (cy >>> cstep));
        sin_q <= cflip ? -(cy + (cx >>> cstep)) : (cy + (cx >>> cstep));
      end else begin
        cos_q <= cflip ? -(cx + (cy >>> cstep)) : (cx + (cy >>> cstep));
        sin_q <= cflip ? -(cy - (cx >>> cstep)) : (cy - (cx >>> cstep));
      end
    end
  end

  // ---------------- pipeline enable
  logic en;
  logic pix_ok;
  assign pix_ok = ~cbusy & ~angle_dirty;
  assign en = ~(out_valid & out_stall);
  assign in_stall = ~en | ~pix_ok;

  logic in_take;
  assign in_take = in_valid & ~in_stall;

  // Item payload kept alongside control through the long pipeline
  typedef struct packed {
    logic [1:0]  shape;
    logic        inv;
    wmb_in_t     px;
  } carry_t;

  // ---------------- stage 1: offsets
  logic               s1_v;
  carry_t             s1_c;
  logic signed [18:0] s1_dx, s1_dy;
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= in_take;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_c  <= '{shape: mode[1:0], inv: mode[2], px: in_word};
      s1_dx <= signed'({3'b000, in_word.pos_h}) - 19'(ctr_h);
      s1_dy <= signed'({3'b000, in_word.pos_v}) - 19'(ctr_v);
    end
  end

  // ---------------- stage 2: four products
  logic               s2_v;
  carry_t             s2_c;
  logic signed [52:0] p_cx, p_sy, p_sx, p_cy;
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_c <= s1_c;
      p_cx <= 53'(cos_q) * 53'(s1_dx);
      p_sy <= 53'(sin_q) * 53'(s1_dy);
      p_sx <= 53'(sin_q) * 53'(s1_dx);
      p_cy <= 53'(cos_q) * 53'(s1_dy);
    end
  end

  // ---------------- stage 3: rotated offsets and divider inputs
  logic signed [53:0] sum_x, sum_y;
  logic signed [23:0] rx_c, ry_c;
  always_comb begin
    sum_x = 54'(p_cx) - 54'(p_sy) + 54'sd536870912;
    sum_y = 54'(p_sx) + 54'(p_cy) + 54'sd536870912;
    rx_c  = 24'(sum_x >>> 30);
    ry_c  = 24'(sum_y >>> 30);
  end

  logic               s3_v;
  carry_t             s3_c;
  logic signed [23:0] s3_rx, s3_ry;
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_c <= s2_c; s3_rx <= rx_c; s3_ry <= ry_c;
    end
  end

  // Axis ratios: u from x (doubled unless gradient), v from y
  logic [24:0] mag_x, mag_y;
  logic [DB-1:0] den_x, den_y;
  logic        lin3;
  always_comb begin
    lin3  = s3_c.shape[1];
    mag_x = lin3 ? 25'(s3_rx < 0 ? -s3_rx : s3_rx)
                 : 25'(s3_rx < 0 ? -s3_rx : s3_rx) << 1;
    mag_y = 25'(s3_ry < 0 ? -s3_ry : s3_ry) << 1;
    den_x = lin3 ? ((size_h > 18'(EPS_I)) ? DB'(size_h) : DB'(EPS_I)) : DB'(size_h);
    den_y = DB'(size_v);
  end

  typedef struct packed {
    carry_t c;
    logic   neg_x;
  } dtag_t;

  localparam int DTB = $bits(dtag_t);
  logic          dx_v, dy_v;
  logic [QB-1:0] qx, qy;
  logic          ox, oy;
  dtag_t         dx_t;
  logic [DTB-1:0] dx_tb, dy_tb;

  wmb_div #(.NUM_BITS(NB), .DEN_BITS(DB), .Q_BITS(QB), .TAG_BITS(DTB)) u_div_x (
    .clk, .rst, .en, .in_valid(s3_v),
    .num(NB'(mag_x) << FRAC_BITS), .den(den_x),
    .tag_in(DTB'({s3_c, s3_rx < 0})),
    .out_valid(dx_v), .quo(qx), .ovf(ox), .tag_out(dx_tb)
  );
  wmb_div #(.NUM_BITS(NB), .DEN_BITS(DB), .Q_BITS(QB), .TAG_BITS(DTB)) u_div_y (
    .clk, .rst, .en, .in_valid(s3_v),
    .num(NB'(mag_y) << FRAC_BITS), .den(den_y),
    .tag_in('0),
    .out_valid(dy_v), .quo(qy), .ovf(oy), .tag_out(dy_tb)
  );
  assign dx_t = dtag_t'(dx_tb);

  // ---------------- stage 4: capped ratios, squares
  localparam int UB = FRAC_BITS + 2;
  logic [UB:0] u_c, v_c;
  always_comb begin
    u_c = (ox || ({1'b0, qx} > (UB+1)'(2 * ONE_I))) ? (UB+1)'(2 * ONE_I) : {1'b0, qx};
    v_c = (oy || ({1'b0, qy} > (UB+1)'(2 * ONE_I))) ? (UB+1)'(2 * ONE_I) : {1'b0, qy};
  end

  logic              s4_v;
  dtag_t             s4_t;
  logic [UB:0]       s4_u, s4_v2;
  logic [2*UB+2:0]   s4_sq;
  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (en) s4_v <= dx_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_t  <= dx_t; s4_u <= u_c; s4_v2 <= v_c;
      s4_sq <= (2*UB+3)'(u_c) * (2*UB+3)'(u_c);
    end
  end
  logic [2*UB+2:0] s5_sq;
  logic            s5_v;
  dtag_t           s5_t;
  logic [UB:0]     s5_u, s5_v2;
  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else if (en) s5_v <= s4_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_t <= s4_t; s5_u <= s4_u; s5_v2 <= s4_v2;
      s5_sq <= s4_sq + (2*UB+3)'(s4_v2) * (2*UB+3)'(s4_v2);
    end
  end

  // ---------------- square root, one result bit per stage
  localparam int RB = UB + 2;           // root bits
  localparam int SB = 2 * RB;           // radicand bits
  typedef struct packed {
    dtag_t       t;
    logic [UB:0] u;
    logic [UB:0] v;
  } rtag_t;

  logic [SB-1:0] rr_rem [RB+1];
  logic [RB-1:0] rr_rt  [RB+1];
  logic [SB-1:0] rr_rad [RB+1];
  rtag_t         rr_t   [RB+1];
  logic          rr_v   [RB+1];
  always_comb begin
    rr_rem[0] = '0; rr_rt[0] = '0;
    rr_rad[0] = SB'(s5_sq);
    rr_t[0]   = '{t: s5_t, u: s5_u, v: s5_v2};
    rr_v[0]   = s5_v;
  end
  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    logic [SB-1:0] rem_n, trial;
    always_comb begin
      rem_n = (rr_rem[k] << 2) | SB'(rr_rad[k][SB-1-2*k -: 2]);
      trial = SB'({rr_rt[k], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (rst) rr_v[k+1] <= 1'b0;
      else if (en) rr_v[k+1] <= rr_v[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rr_rad[k+1] <= rr_rad[k];
        rr_t[k+1]   <= rr_t[k];
        if (rem_n >= trial) begin
          rr_rem[k+1] <= rem_n - trial;
          rr_rt[k+1]  <= {rr_rt[k][RB-2:0], 1'b1};
        end else begin
          rr_rem[k+1] <= rem_n;
          rr_rt[k+1]  <= {rr_rt[k][RB-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- stage: distance and feather numerator
  rtag_t              rt;
  logic signed [UB+2:0] win_dist;
  always_comb begin
    rt = rr_t[RB];
    case (rt.t.c.shape)
      SHAPE_ELLIPSE: win_dist = (UB+3)'(rr_rt[RB]);
      SHAPE_RECT:    win_dist = (rt.u > rt.v) ? (UB+3)'(rt.u) : (UB+3)'(rt.v);
      default: win_dist = (rt.t.neg_x ? -(UB+3)'(rt.u) : (UB+3)'(rt.u))
                          + (UB+3)'(ONE_I / 2);
    endcase
  end

  logic [17:0] f_use;
  assign f_use = (feather > 18'(EPS_I)) ? feather : 18'(EPS_I);

  logic                 s6_v;
  carry_t               s6_c;
  logic signed [UB+2:0] s6_d;
  logic signed [UB+3:0] s6_num;
  always_ff @(posedge clk) begin
    if (rst) s6_v <= 1'b0;
    else if (en) s6_v <= rr_v[RB];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s6_c   <= rt.t.c;
      s6_d   <= win_dist;
      s6_num <= (UB+4)'(win_dist) - (UB+4)'(ONE_I) + (UB+4)'(f_use);
    end
  end

  // Feather ramp divider
  typedef struct packed {
    carry_t               c;
    logic signed [UB+2:0] d;
    logic                 pos;
  } ftag_t;
  localparam int FTB = $bits(ftag_t);
  logic          f_vo;
  logic [QB-1:0] fq;
  logic          fo;
  logic [FTB-1:0] f_tb;
  ftag_t         ft;
  wmb_div #(.NUM_BITS(NB), .DEN_BITS(DB), .Q_BITS(QB), .TAG_BITS(FTB)) u_div_f (
    .clk, .rst, .en, .in_valid(s6_v),
    .num(s6_num > 0 ? NB'(s6_num) << FRAC_BITS : '0), .den(DB'(f_use)),
    .tag_in(FTB'({s6_c, s6_d, s6_num > 0})),
    .out_valid(f_vo), .quo(fq), .ovf(fo), .tag_out(f_tb)
  );
  assign ft = ftag_t'(f_tb);

  // ---------------- stage 7: matte and strength product
  logic signed [UB+3:0] m0, m1;
  always_comb begin
    if (ft.c.shape == SHAPE_LINEAR) begin
      m0 = (UB+4)'(ONE_I) - (UB+4)'(ft.d);
      if (m0 < 0) m0 = '0;
      else if (m0 > (UB+4)'(ONE_I)) m0 = (UB+4)'(ONE_I);
    end else if (!ft.pos) begin
      m0 = (UB+4)'(ONE_I);
    end else if (fo || {1'b0, fq} > (QB+1)'(ONE_I)) begin
      m0 = '0;
    end else begin
      m0 = (UB+4)'(ONE_I) - (UB+4)'(fq);
    end
    m1 = ft.c.inv ? (UB+4)'(ONE_I) - m0 : m0;
  end

  logic                     s7_v;
  carry_t                   s7_c;
  logic [FRAC_BITS+17:0]    s7_p;
  always_ff @(posedge clk) begin
    if (rst) s7_v <= 1'b0;
    else if (en) s7_v <= f_vo;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s7_c <= ft.c;
      s7_p <= (FRAC_BITS+18)'(m1[FRAC_BITS:0]) * (FRAC_BITS+18)'(strength) + 32768;
    end
  end

  // ---------------- stage 8: clamp matte
  logic [FRAC_BITS:0] m_fin;
  always_comb begin
    m_fin = ((s7_p >> 16) > (FRAC_BITS+18)'(ONE_I)) ? (FRAC_BITS+1)'(ONE_I)
                                                   : (FRAC_BITS+1)'(s7_p >> 16);
  end
  logic               s8_v;
  carry_t             s8_c;
  logic [FRAC_BITS:0] s8_m;
  always_ff @(posedge clk) begin
    if (rst) s8_v <= 1'b0;
    else if (en) s8_v <= s7_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s8_c <= s7_c; s8_m <= m_fin;
    end
  end

  // ---------------- stage 9: blend products
  localparam int PB = CHANNEL_BITS + FRAC_BITS + 3;
  logic [CHANNEL_BITS-1:0] ar, ag, ab, br, bg, bb;
  assign ar = s8_c.px.src_red[CHANNEL_BITS-1:0];
  assign ag = s8_c.px.src_green[CHANNEL_BITS-1:0];
  assign ab = s8_c.px.src_blue[CHANNEL_BITS-1:0];
  assign br = s8_c.px.graded_red[CHANNEL_BITS-1:0];
  assign bg = s8_c.px.graded_green[CHANNEL_BITS-1:0];
  assign bb = s8_c.px.graded_blue[CHANNEL_BITS-1:0];

  logic signed [PB-1:0] pr, pg, pb;
  logic                 s9_v;
  carry_t               s9_c;
  logic [FRAC_BITS:0]   s9_m;
  always_ff @(posedge clk) begin
    if (rst) s9_v <= 1'b0;
    else if (en) s9_v <= s8_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s9_c <= s8_c; s9_m <= s8_m;
      pr <= (PB'(signed'({1'b0, br})) - PB'(signed'({1'b0, ar}))) * PB'(signed'({1'b0, s8_m}));
      pg <= (PB'(signed'({1'b0, bg})) - PB'(signed'({1'b0, ag}))) * PB'(signed'({1'b0, s8_m}));
      pb <= (PB'(signed'({1'b0, bb})) - PB'(signed'({1'b0, ab}))) * PB'(signed'({1'b0, s8_m}));
    end
  end

  // ---------------- output register
  function automatic logic [15:0] mix_out(input logic [15:0] a, input logic signed [PB-1:0] p);
    logic signed [PB-1:0] r;
    r = (p + PB'(ONE_I / 2)) >>> FRAC_BITS;
    mix_out = 16'(PB'(signed'({1'b0, a[CHANNEL_BITS-1:0]})) + r);
  endfunction

  logic [16:0] mq;
  always_comb begin
    if (SH > 0) mq = 17'((18'(s9_m) + 18'(1 << (SH > 0 ? SH - 1 : 0))) >> SH);
    else mq = 17'(s9_m) << (-SH);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= s9_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_word.out_red     <= mix_out(s9_c.px.src_red, pr);
      out_word.out_green   <= mix_out(s9_c.px.src_green, pg);
      out_word.out_blue    <= mix_out(s9_c.px.src_blue, pb);
      out_word.out_alpha   <= 16'(s9_c.px.src_alpha[CHANNEL_BITS-1:0]);
      out_word.matte_value <= mq;
    end
  end

  // ---------------- checks
  `WMB_ASSERT_IMP(a_no_pix_busy, clk, rst, cbusy, in_stall)
  `WMB_ASSERT_NXT(a_hold_out, clk, rst, out_valid && out_stall, out_valid)
  `WMB_ASSERT_IMP(a_matte_max, clk, rst, out_valid, out_word.matte_value <= 17'd65536)
  `WMB_ASSERT_IMP(a_lanes_match, clk, rst, 1'b1, dx_v == dy_v)
endmodule

// ----- tb/sv/window_matte_blend_check.sv -----
// Checker for the window matte blend block: predicts every pixel word and compares.
module window_matte_blend_check
  import wmb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  wmb_in_t     in_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  wmb_out_t    out_word,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE  = 64'sd65536;
  localparam longint EPS  = 64'sd7;
  localparam longint GAIN = 64'sd652032875;
  localparam longint ANGLE_TURN [18] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860, 10430,
    5215, 2608, 1304, 652, 326, 163, 81, 41, 20};

  // Window settings as seen on the configuration channel
  logic [2:0]         mode_q;
  logic signed [17:0] cen_h_q, cen_v_q;
  logic signed [15:0] angle_q;
  logic [17:0]        size_h_q, size_v_q, feather_q;
  logic [16:0]        strength_q;

  wmb_out_t blend_queue[$];

  // Signed axis ratio |num|/den, capped at 2.0
  function automatic longint axis_ratio(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    if (den <= 0) q = 2 * ONE;
    else begin
      q = (mag <<< 16) / den;
      if (q > 2 * ONE) q = 2 * ONE;
    end
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] mix_chan(logic [15:0] a, logic [15:0] b, longint m);
    longint r;
    r = longint'(a) + ((((longint'(b) - longint'(a)) * m) + ONE / 2) >>> 16);
    return r[15:0];
  endfunction

  function automatic wmb_out_t predict_blend(wmb_in_t w);
    wmb_out_t o;
    longint th, x, y, z, nx, ny, c, s, dx, dy, rx, ry, u, v, d, m, f, num, t, wd;
    logic flip;
    // rotation by the negated angle, CORDIC in quarter-folded range
    th = -longint'(angle_q);
    flip = 1'b0;
    if (th > 16384) begin th = th - 32768; flip = 1'b1; end
    else if (th < -16384) begin th = th + 32768; flip = 1'b1; end
    x = GAIN; y = 0; z = th * 256;
    for (int i = 0; i < 18; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z = z - ANGLE_TURN[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z = z + ANGLE_TURN[i];
      end
      x = nx; y = ny;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    dx = longint'(w.pos_h) - longint'(cen_h_q);
    dy = longint'(w.pos_v) - longint'(cen_v_q);
    rx = (c * dx - s * dy + (64'sd1 <<< 29)) >>> 30;
    ry = (s * dx + c * dy + (64'sd1 <<< 29)) >>> 30;
    // distance by shape
    if (mode_q[1] == 1'b0) begin
      u = axis_ratio(2 * rx, longint'(size_h_q));
      v = axis_ratio(2 * ry, longint'(size_v_q));
      if (u < 0) u = -u;
      if (v < 0) v = -v;
      if (mode_q[1:0] == SHAPE_ELLIPSE) d = root_floor(u * u + v * v);
      else d = (u > v) ? u : v;
    end else begin
      wd = longint'(size_h_q);
      d = axis_ratio(rx, (wd > EPS) ? wd : EPS) + ONE / 2;
    end
    // matte: clamped ramp for the gradient, feathered edge otherwise
    if (mode_q[1:0] == SHAPE_LINEAR) begin
      m = ONE - d;
      if (m < 0) m = 0;
      if (m > ONE) m = ONE;
    end else begin
      f = (longint'(feather_q) > EPS) ? longint'(feather_q) : EPS;
      num = d - ONE + f;
      t = 0;
      if (num > 0) begin
        t = (num <<< 16) / f;
        if (t > ONE) t = ONE;
      end
      m = ONE - t;
    end
    if (mode_q[2]) m = ONE - m;
    m = (m * longint'(strength_q) + 32768) >>> 16;
    if (m < 0) m = 0;
    if (m > ONE) m = ONE;
    o.out_red     = mix_chan(w.src_red, w.graded_red, m);
    o.out_green   = mix_chan(w.src_green, w.graded_green, m);
    o.out_blue    = mix_chan(w.src_blue, w.graded_blue, m);
    o.out_alpha   = w.src_alpha;
    o.matte_value = m[16:0];
    return o;
  endfunction

  assign pending = blend_queue.size();

  // Follow settings, queue predictions, compare results
  always @(posedge clk) begin
    wmb_out_t want;
    if (rst) begin
      mode_q <= 3'd0; cen_h_q <= 18'sd32768; cen_v_q <= 18'sd32768; angle_q <= 16'sd0;
      size_h_q <= 18'd65536; size_v_q <= 18'd65536; feather_q <= 18'd6554;
      strength_q <= 17'd65536;
      blend_queue.delete();
      mismatches <= 0;
      checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:     mode_q     <= cfg_data[2:0];
          REG_CENTER_H: cen_h_q    <= cfg_data[17:0];
          REG_CENTER_V: cen_v_q    <= cfg_data[17:0];
          REG_ANGLE:    angle_q    <= cfg_data[15:0];
          REG_SIZE_H:   size_h_q   <= cfg_data[17:0];
          REG_SIZE_V:   size_v_q   <= cfg_data[17:0];
          REG_FEATHER:  feather_q  <= cfg_data[17:0];
          REG_STRENGTH: strength_q <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        blend_queue.insert(blend_queue.size(), predict_blend(in_word));
      if (out_valid && !out_stall) begin
        checked <= checked + 1;
        if (blend_queue.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected output word %h", out_word);
        end else begin
          want = blend_queue.pop_front();
          if (want.out_red !== out_word.out_red || want.out_green !== out_word.out_green ||
              want.out_blue !== out_word.out_blue || want.out_alpha !== out_word.out_alpha ||
              want.matte_value !== out_word.matte_value) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch rgba/matte exp %h %h %h %h %h got %h %h %h %h %h",
                       want.out_red, want.out_green, want.out_blue, want.out_alpha,
                       want.matte_value, out_word.out_red, out_word.out_green,
                       out_word.out_blue, out_word.out_alpha, out_word.matte_value);
          end
        end
      end
    end
  end
endmodule

// ----- tb/sv/window_matte_blend_test.sv -----
// Testbench top for the window matte blend block: stimulus, settings and verdict.
module window_matte_blend_test;
  import wmb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_INVERT = 3'b100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  wmb_in_t     in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  wmb_out_t    out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_MODE;
  logic [31:0] cfg_data = '0;
  int          mismatches, pending, checked;
  int          tx_idle_pct = 0, rx_idle_pct = 0;
  int          settings_done = 0;

  window_matte_blend dut (.*);

  window_matte_blend_check check (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver stall pattern
  always @(posedge clk) out_stall <= ($urandom_range(99) < rx_idle_pct);

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold off until every queued pixel has come back
  task automatic drain();
    while (pending != 0) @(posedge clk);
  endtask

  task automatic push_pixel(wmb_in_t w);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic wmb_in_t random_pixel();
    wmb_in_t w;
    w = wmb_in_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    return w;
  endfunction

  function automatic logic [17:0] pick_span(int hi);
    case ($urandom_range(0, 9))
      0: return 18'd0;
      1: return 18'h3FFFF;
      2: return 18'($urandom_range(1, 20));
      default: return 18'($urandom_range(1024, hi));
    endcase
  endfunction

  task automatic random_window(int blk);
    logic [31:0] st;
    write_reg(REG_MODE, 32'($urandom_range(0, 7)));
    if (blk == 0) begin
      // negative extremes of center and angle
      write_reg(REG_CENTER_H, 32'h20000);
      write_reg(REG_CENTER_V, 32'h20000);
      write_reg(REG_ANGLE, 32'h8000);
      write_reg(REG_SIZE_H, 32'd0);
      write_reg(REG_SIZE_V, 32'h3FFFF);
      write_reg(REG_FEATHER, 32'd0);
      write_reg(REG_STRENGTH, 32'd0);
    end else if (blk == 1) begin
      // positive extremes of center and angle
      write_reg(REG_CENTER_H, 32'h1FFFF);
      write_reg(REG_CENTER_V, 32'h1FFFF);
      write_reg(REG_ANGLE, 32'h7FFF);
      write_reg(REG_SIZE_H, 32'h3FFFF);
      write_reg(REG_SIZE_V, 32'd0);
      write_reg(REG_FEATHER, 32'h3FFFF);
      write_reg(REG_STRENGTH, 32'h1FFFF);
    end else begin
      write_reg(REG_CENTER_H, $urandom_range(0, 1) ? 32'($urandom_range(0, 65536))
                                                  : 32'($urandom_range(0, 18'h3FFFF)));
      write_reg(REG_CENTER_V, $urandom_range(0, 1) ? 32'($urandom_range(0, 65536))
                                                  : 32'($urandom_range(0, 18'h3FFFF)));
      write_reg(REG_ANGLE, 32'($urandom_range(0, 16'hFFFF)));
      write_reg(REG_SIZE_H, 32'(pick_span(131072)));
      write_reg(REG_SIZE_V, 32'(pick_span(131072)));
      write_reg(REG_FEATHER, 32'(pick_span(40000)));
      case ($urandom_range(0, 9))
        0: st = 32'd0;
        1: st = 32'd65536;
        2: st = 32'($urandom_range(65537, 131071));
        default: st = 32'($urandom_range(0, 65536));
      endcase
      write_reg(REG_STRENGTH, st);
    end
    settings_done++;
  endtask

  initial begin
    wmb_in_t w;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: each shape, inversion, zero size, sub-epsilon width, strength over full
    for (int d = 0; d < 6; d++) begin
      in_valid <= 1'b0;
      drain();
      case (d)
        1: write_reg(REG_MODE, 32'(SHAPE_RECT));
        2: write_reg(REG_MODE, 32'(SHAPE_LINEAR));
        3: write_reg(REG_MODE, 32'(MODE_INVERT | 3'd3));
        4: begin
          write_reg(REG_MODE, 32'(MODE_INVERT | SHAPE_ELLIPSE));
          write_reg(REG_SIZE_H, 32'd0);
          write_reg(REG_SIZE_V, 32'd0);
        end
        5: begin
          write_reg(REG_MODE, 32'(SHAPE_LINEAR));
          write_reg(REG_SIZE_H, 32'd3);
          write_reg(REG_FEATHER, 32'd0);
          write_reg(REG_STRENGTH, 32'h1FFFF);
        end
        default: ;
      endcase
      settings_done++;
      for (int k = 0; k < 4; k++) begin
        case (k)
          0: w = '0;
          1: w = '1;
          2: begin
            w = random_pixel();
            w.pos_h = 16'd32768; w.pos_v = 16'd32768;
            w.src_red = 16'h0; w.src_green = 16'h0; w.src_blue = 16'h0;
            w.graded_red = 16'hFFFF; w.graded_green = 16'hFFFF; w.graded_blue = 16'hFFFF;
          end
          default: w = random_pixel();
        endcase
        push_pixel(w);
      end
    end

    // Random: twelve window settings over three idling phases
    for (int blk = 0; blk < 12; blk++) begin
      in_valid <= 1'b0;
      drain();
      if (blk < 4) begin tx_idle_pct = 14; rx_idle_pct = 61; end
      else if (blk < 8) begin tx_idle_pct = 61; rx_idle_pct = 14; end
      else begin tx_idle_pct = 0; rx_idle_pct = 0; end
      random_window(blk);
      for (int n = 0; n < 140; n++) push_pixel(random_pixel());
    end
    in_valid <= 1'b0;
    drain();
    repeat (100) @(posedge clk);

    $display("Covered %0d pixels over %0d window settings: all shapes, invert, zero size,",
             checked, settings_done);
    $display("strength and feather extremes, with both sides stalling and free running.");
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("timeout waiting for pixel words");
    $display("DONE: errors detected");
    $finish;
  end
endmodule
